// ===== rtl/ascon_pkg.sv =====
// ----------------------------------------------------------------------------
// Ascon AEAD engine package
// Shared types, action codes and the Ascon round function.
// ----------------------------------------------------------------------------
`default_nettype none
package ascon_pkg;
	localparam int FullRounds = 12;

	localparam logic [2:0] ACT_START    = 3'd0;
	localparam logic [2:0] ACT_AD_BYTE  = 3'd1;
	localparam logic [2:0] ACT_END_AD   = 3'd2;
	localparam logic [2:0] ACT_PL_BYTE  = 3'd3;
	localparam logic [2:0] ACT_END_PL   = 3'd4;
	localparam logic [2:0] ACT_FINALIZE = 3'd5;
	localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
	localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

	localparam logic [2:0] CFG_KEY_UPPER = 3'd0;
	localparam logic [2:0] CFG_KEY_LOWER = 3'd1;
	localparam logic [2:0] CFG_RATE_SEL  = 3'd2;
	localparam logic [2:0] CFG_ROUNDS    = 3'd3;
	localparam logic [2:0] CFG_MODE      = 3'd4;

	localparam logic [1:0] MODE_ENC    = 2'd0;
	localparam logic [1:0] MODE_DEC    = 2'd1;
	localparam logic [1:0] MODE_ABSORB = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam int QueueDepth = 2;

	typedef logic [63:0] word_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  data_byte;
		logic [63:0] nonce_upper;
		logic [63:0] nonce_lower;
	} cmd_t;

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

	// one Ascon round with round constant index c
	function automatic logic [319:0] ascon_round(input logic [319:0] st, input logic [3:0] c);
		word_t s0, s1, s2, s3, s4, t0, t1, t2, t3, t4;
		s0 = st[63:0];
		s1 = st[127:64];
		s2 = st[191:128] ^ {56'd0, 4'(4'd15 - c), c};
		s3 = st[255:192];
		s4 = st[319:256];
		t0 = s3 ^ s4 ^ (s1 | (s0 ^ s2 ^ s4));
		t1 = s0 ^ s4 ^ ((s1 ^ s2) | (s2 ^ s3));
		t2 = s1 ^ s2 ^ (s3 | ~s4);
		t3 = s1 ^ s2 ^ (s0 | (s3 ^ s4));
		t4 = s3 ^ s4 ^ (s1 & ~(s0 ^ s4));
		ascon_round = {t4 ^ rotr(t4, 7) ^ rotr(t4, 41),
			t3 ^ rotr(t3, 10) ^ rotr(t3, 17),
			t2 ^ rotr(t2, 1) ^ rotr(t2, 6),
			t1 ^ rotr(t1, 61) ^ rotr(t1, 39),
			t0 ^ rotr(t0, 19) ^ rotr(t0, 28)};
	endfunction
endpackage
`default_nettype wire

// ===== rtl/ascon_front.sv =====
// ----------------------------------------------------------------------------
// Ascon front end
// Accepts stream requests, drops unused action codes and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none
module ascon_front
	import ascon_pkg::*;
#(
	parameter int Depth = QueueDepth
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire cmd_t in_cmd,
	output logic      q_valid,
	input  wire logic q_ready,
	output cmd_t      q_cmd
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	cmd_t            mem_q [Depth];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     cnt_q;
	logic            push, pop, keep;

	assign keep     = in_cmd.action <= ACT_FINALIZE;
	assign in_ready = cnt_q != (AW+1)'(Depth);
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = cnt_q != '0;
	assign pop      = q_valid && q_ready;
	assign q_cmd    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ascon_back.sv =====
// ----------------------------------------------------------------------------
// Ascon back end
// Holds the sponge state, runs one permutation round per cycle and drives
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module ascon_back
	import ascon_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	output logic             q_ready,
	input  wire cmd_t        q_cmd,
	input  wire logic [63:0] key_upper,
	input  wire logic [63:0] key_lower,
	input  wire logic        rate_select,
	input  wire logic [3:0]  inner_rounds,
	input  wire logic [1:0]  cipher_mode,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             is_tag,
	output logic [63:0]      tag_upper,
	output logic [63:0]      tag_lower
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PERM = 2'd1;
	localparam logic [1:0] ST_POST = 2'd2;

	logic [1:0]   state_q;
	logic [319:0] s_q;
	logic [3:0]   pos_q;
	logic         ad_seen_q;
	logic [3:0]   rc_q;       // current round constant index
	logic [3:0]   left_q;     // rounds remaining
	logic [2:0]   post_q;     // action that finishes after the rounds

	logic [3:0]   mask, p, eff_rounds;
	logic [127:0] rate_bits;
	logic [6:0]   sh;
	logic [7:0]   sb;
	logic         full;
	logic         res_load;

	assign mask       = rate_select ? 4'd15 : 4'd7;
	assign p          = pos_q & mask;
	assign eff_rounds = (inner_rounds > 4'(FullRounds)) ? 4'(FullRounds) : inner_rounds;
	assign rate_bits  = {s_q[63:0], s_q[127:64]};
	assign sh         = 7'(7'd120 - {p, 3'b000});
	assign sb         = 8'(rate_bits >> sh);
	assign full       = p == mask;
	assign q_ready    = (state_q == ST_IDLE) && !(out_valid && !out_ready);
	// a payload byte in encrypt or decrypt, or the end of finalize, loads a result
	assign res_load   = ((state_q == ST_IDLE) && q_valid && q_ready &&
		(q_cmd.action == ACT_PL_BYTE) &&
		(cipher_mode == MODE_ENC || cipher_mode == MODE_DEC)) ||
		((state_q == ST_POST) && (post_q == ACT_FINALIZE));

	function automatic logic [319:0] xor_at(input logic [319:0] st, input logic [3:0] pp,
		input logic [7:0] v);
		logic [127:0] r;
		r = {st[63:0], st[127:64]} ^ (128'(v) << (7'd120 - {pp, 3'b000}));
		xor_at = {st[319:128], r[63:0], r[127:64]};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			s_q       <= '0;
			pos_q     <= '0;
			ad_seen_q <= 1'b0;
			rc_q      <= '0;
			left_q    <= '0;
			post_q    <= ACT_START;
			out_valid <= 1'b0;
			out_byte  <= '0;
			is_tag    <= 1'b0;
			tag_upper <= '0;
			tag_lower <= '0;
		end else begin
			if (res_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && q_ready) begin
						post_q <= q_cmd.action;
						unique case (q_cmd.action)
							ACT_START: begin
								s_q <= {q_cmd.nonce_lower, q_cmd.nonce_upper, key_lower, key_upper,
									8'h80, rate_select ? 8'h80 : 8'h40, 8'd12, 4'd0, inner_rounds, 32'd0};
								rc_q      <= 4'd0;
								left_q    <= 4'(FullRounds);
								state_q   <= ST_PERM;
								pos_q     <= '0;
								ad_seen_q <= 1'b0;
							end
							ACT_AD_BYTE: begin
								s_q       <= xor_at(s_q, p, q_cmd.data_byte);
								ad_seen_q <= 1'b1;
								pos_q     <= full ? 4'd0 : p + 4'd1;
								if (full && eff_rounds != 0) begin
									rc_q    <= 4'(4'd12 - eff_rounds);
									left_q  <= eff_rounds;
									state_q <= ST_PERM;
								end
							end
							ACT_END_AD: begin
								pos_q     <= '0;
								ad_seen_q <= 1'b0;
								if (ad_seen_q) begin
									s_q     <= xor_at(s_q, p, 8'h80);
									rc_q    <= 4'(4'd12 - eff_rounds);
									left_q  <= eff_rounds;
									state_q <= (eff_rounds != 0) ? ST_PERM : ST_POST;
								end else begin
									s_q[256] <= ~s_q[256];
								end
							end
							ACT_PL_BYTE: begin
								if (cipher_mode == MODE_DEC) begin
									s_q <= xor_at(xor_at(s_q, p, sb), p, q_cmd.data_byte);
								end else begin
									s_q <= xor_at(s_q, p, q_cmd.data_byte);
								end
								if (cipher_mode == MODE_ENC || cipher_mode == MODE_DEC) begin
									out_byte  <= sb ^ q_cmd.data_byte;
									is_tag    <= 1'b0;
									tag_upper <= '0;
									tag_lower <= '0;
								end
								pos_q <= full ? 4'd0 : p + 4'd1;
								if (full && eff_rounds != 0) begin
									rc_q    <= 4'(4'd12 - eff_rounds);
									left_q  <= eff_rounds;
									state_q <= ST_PERM;
								end
							end
							ACT_END_PL: begin
								s_q   <= xor_at(s_q, p, 8'h80);
								pos_q <= '0;
							end
							ACT_FINALIZE: begin
								if (rate_select) begin
									s_q[191:128] <= s_q[191:128] ^ key_upper;
									s_q[255:192] <= s_q[255:192] ^ key_lower;
								end else begin
									s_q[127:64]  <= s_q[127:64] ^ key_upper;
									s_q[191:128] <= s_q[191:128] ^ key_lower;
								end
								rc_q      <= 4'd0;
								left_q    <= 4'(FullRounds);
								state_q   <= ST_PERM;
								pos_q     <= '0;
								ad_seen_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_PERM: begin
					s_q    <= ascon_round(s_q, rc_q);
					rc_q   <= rc_q + 4'd1;
					left_q <= left_q - 4'd1;
					if (left_q == 4'd1) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					state_q <= ST_IDLE;
					case (post_q)
						ACT_START: begin
							s_q[255:192] <= s_q[255:192] ^ key_upper;
							s_q[319:256] <= s_q[319:256] ^ key_lower;
						end
						ACT_END_AD: s_q[256] <= ~s_q[256];
						ACT_FINALIZE: begin
							out_byte  <= '0;
							is_tag    <= 1'b1;
							tag_upper <= s_q[255:192] ^ key_upper;
							tag_lower <= s_q[319:256] ^ key_lower;
						end
						default: ;
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ascon_aead_engine_top.sv =====
// ----------------------------------------------------------------------------
// Ascon AEAD engine top level
// Configuration registers, front queue and sponge back end.
// ----------------------------------------------------------------------------
// Byte requests that need no permutation are handled by the back end in idle; a
// full rate block, a padded associated-data end, start and finalize also run the
// rounds (inner_rounds capped at 12; 12 for start and finalize) and a finishing
// state on the single shared round unit. A two-entry queue separates request
// intake from the sponge, and one output register holds a result until taken.
`default_nettype none
module ascon_aead_engine_top
	import ascon_pkg::*;
#(
	parameter int Depth = QueueDepth
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [135:0] s_axis_tdata,  // data_byte[7:0], nonce_upper, nonce_lower
	input  wire logic [2:0]   s_axis_tuser,  // action
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [135:0]      m_axis_tdata,  // out_byte[7:0], tag_upper, tag_lower
	output logic              m_axis_tuser,  // is_tag
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [63:0]  cfg_data
);
	logic [63:0] key_upper_q, key_lower_q;
	logic        rate_q;
	logic [3:0]  rounds_q;
	logic [1:0]  mode_q;
	cmd_t        in_cmd, q_cmd;
	logic        q_valid, q_ready;
	logic [7:0]  out_byte;
	logic [63:0] tag_upper, tag_lower;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_lower_q <= '0;
			rate_q      <= 1'b0;
			rounds_q    <= 4'd6;
			mode_q      <= MODE_ENC;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_UPPER: key_upper_q <= cfg_data;
				CFG_KEY_LOWER: key_lower_q <= cfg_data;
				CFG_RATE_SEL:  rate_q      <= cfg_data[0];
				CFG_ROUNDS:    rounds_q    <= cfg_data[3:0];
				CFG_MODE:      mode_q      <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign in_cmd = '{action: s_axis_tuser, data_byte: s_axis_tdata[7:0],
		nonce_upper: s_axis_tdata[71:8], nonce_lower: s_axis_tdata[135:72]};

	ascon_front #(.Depth(Depth)) u_front (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd,
		.q_valid, .q_ready, .q_cmd
	);

	ascon_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cmd,
		.key_upper(key_upper_q), .key_lower(key_lower_q), .rate_select(rate_q),
		.inner_rounds(rounds_q), .cipher_mode(mode_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_byte, .is_tag(m_axis_tuser), .tag_upper, .tag_lower
	);

	assign m_axis_tdata = {tag_lower, tag_upper, out_byte};
endmodule
`default_nettype wire

// ===== rtl/ascon_checker.sv =====
// ----------------------------------------------------------------------------
// Ascon engine port checker
// Watches the output stream port of the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module ascon_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [135:0] m_axis_tdata,
	input wire logic         m_axis_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");
	a_tag_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
		else $error("tag result carries a byte");
	a_byte_tag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[135:8] == '0)
		else $error("byte result carries a tag");
endmodule

bind ascon_aead_engine_top ascon_checker u_checker (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
`default_nettype wire

// ===== sim/ascon_aead_engine_top_tb.sv =====
// ----------------------------------------------------------------------------
// Ascon AEAD engine testbench
// Drives start, associated-data, payload, end and finalize requests through
// the stream ports across several key, rate, round and mode settings, with
// random stalls on both sides. A scoreboard predicts every payload byte and
// tag and checks the results field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

class ascon_scoreboard;
	typedef struct {
		logic [7:0]  out_byte;
		logic        is_tag;
		logic [63:0] tag_upper;
		logic [63:0] tag_lower;
	} result_t;

	result_t     pending_results[$];
	int          errors;
	logic [63:0] key_hi, key_lo;
	logic        rate_sel;
	logic [3:0]  rounds_cfg;
	logic [1:0]  mode_cfg;
	logic [63:0] sw[5];
	logic [3:0]  pos;
	logic        ad_seen;

	function new();
		key_hi = '0;
		key_lo = '0;
		rate_sel = 1'b0;
		rounds_cfg = 4'd6;
		mode_cfg = ascon_pkg::MODE_ENC;
		foreach (sw[i]) sw[i] = '0;
		pos = '0;
		ad_seen = 1'b0;
		errors = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [63:0] val);
		case (idx)
			ascon_pkg::CFG_KEY_UPPER: key_hi = val;
			ascon_pkg::CFG_KEY_LOWER: key_lo = val;
			ascon_pkg::CFG_RATE_SEL:  rate_sel = val[0];
			ascon_pkg::CFG_ROUNDS:    rounds_cfg = val[3:0];
			ascon_pkg::CFG_MODE:      mode_cfg = val[1:0];
			default: ;
		endcase
	endfunction

	function logic [63:0] rot(logic [63:0] x, int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	function void permute(int unsigned n);
		logic [63:0] t0, t1, t2, t3, t4;
		logic [3:0]  c;
		if (n > 12) n = 12;
		for (int unsigned i = 0; i < n; i++) begin
			c = 4'(12 - n + i);
			sw[2] ^= {56'd0, 4'(4'd15 - c), c};
			t0 = sw[3] ^ sw[4] ^ (sw[1] | (sw[0] ^ sw[2] ^ sw[4]));
			t1 = sw[0] ^ sw[4] ^ ((sw[1] ^ sw[2]) | (sw[2] ^ sw[3]));
			t2 = sw[1] ^ sw[2] ^ (sw[3] | ~sw[4]);
			t3 = sw[1] ^ sw[2] ^ (sw[0] | (sw[3] ^ sw[4]));
			t4 = sw[3] ^ sw[4] ^ (sw[1] & ~(sw[0] ^ sw[4]));
			sw[0] = t0 ^ rot(t0, 19) ^ rot(t0, 28);
			sw[1] = t1 ^ rot(t1, 61) ^ rot(t1, 39);
			sw[2] = t2 ^ rot(t2, 1) ^ rot(t2, 6);
			sw[3] = t3 ^ rot(t3, 10) ^ rot(t3, 17);
			sw[4] = t4 ^ rot(t4, 7) ^ rot(t4, 41);
		end
	endfunction

	function logic [7:0] get_byte(logic [3:0] p);
		return 8'(sw[p[3]] >> (56 - 8 * p[2:0]));
	endfunction

	function void xor_byte(logic [3:0] p, logic [7:0] v);
		sw[p[3]] ^= {56'd0, v} << (56 - 8 * p[2:0]);
	endfunction

	function void step_pos(logic [3:0] p);
		if (p == (rate_sel ? 4'd15 : 4'd7)) begin
			permute(rounds_cfg);
			pos = '0;
		end else begin
			pos = p + 4'd1;
		end
	endfunction

	// Advance the sponge for one accepted request and queue any result.
	function void note_request(logic [2:0] act, logic [7:0] data, logic [63:0] nu,
			logic [63:0] nl);
		logic [3:0] p;
		logic [7:0] sb;
		result_t    r;
		p = pos & (rate_sel ? 4'd15 : 4'd7);
		case (act)
			ascon_pkg::ACT_START: begin
				sw[0] = {8'h80, (rate_sel ? 8'h80 : 8'h40), 8'd12, 4'd0, rounds_cfg, 32'd0};
				sw[1] = key_hi;
				sw[2] = key_lo;
				sw[3] = nu;
				sw[4] = nl;
				permute(12);
				sw[3] ^= key_hi;
				sw[4] ^= key_lo;
				pos = '0;
				ad_seen = 1'b0;
			end
			ascon_pkg::ACT_AD_BYTE: begin
				xor_byte(p, data);
				ad_seen = 1'b1;
				step_pos(p);
			end
			ascon_pkg::ACT_END_AD: begin
				// pad only if some associated data came
				if (ad_seen) begin
					xor_byte(p, 8'h80);
					permute(rounds_cfg);
				end
				sw[4] ^= 64'd1;
				pos = '0;
				ad_seen = 1'b0;
			end
			ascon_pkg::ACT_PL_BYTE: begin
				sb = get_byte(p);
				xor_byte(p, (mode_cfg == ascon_pkg::MODE_DEC) ? (sb ^ data) : data);
				step_pos(p);
				if (mode_cfg == ascon_pkg::MODE_ENC || mode_cfg == ascon_pkg::MODE_DEC) begin
					r.out_byte = sb ^ data;
					r.is_tag = 1'b0;
					r.tag_upper = '0;
					r.tag_lower = '0;
					pending_results.push_back(r);
				end
			end
			ascon_pkg::ACT_END_PL: begin
				xor_byte(p, 8'h80);
				pos = '0;
			end
			ascon_pkg::ACT_FINALIZE: begin
				sw[rate_sel ? 2 : 1] ^= key_hi;
				sw[rate_sel ? 3 : 2] ^= key_lo;
				permute(12);
				r.out_byte = '0;
				r.is_tag = 1'b1;
				r.tag_upper = sw[3] ^ key_hi;
				r.tag_lower = sw[4] ^ key_lo;
				pending_results.push_back(r);
				pos = '0;
				ad_seen = 1'b0;
			end
			default: ;
		endcase
	endfunction

	function void check_result(logic [135:0] data, logic user);
		result_t r;
		if (pending_results.size() == 0) begin
			$error("unexpected result: tdata=%h tuser=%b", data, user);
			errors++;
			return;
		end
		r = pending_results.pop_front();
		if (data[7:0] !== r.out_byte) begin
			$error("out_byte expected %h actual %h", r.out_byte, data[7:0]);
			errors++;
		end
		if (user !== r.is_tag) begin
			$error("is_tag expected %b actual %b", r.is_tag, user);
			errors++;
		end
		if (data[71:8] !== r.tag_upper) begin
			$error("tag_upper expected %h actual %h", r.tag_upper, data[71:8]);
			errors++;
		end
		if (data[135:72] !== r.tag_lower) begin
			$error("tag_lower expected %h actual %h", r.tag_lower, data[135:72]);
			errors++;
		end
	endfunction
endclass

module ascon_aead_engine_top_tb;
	import ascon_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 20000;
	localparam int DrainCycles = 80;
	localparam int PhaseItems = 50;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata;
	logic [2:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [135:0] m_axis_tdata;
	logic         m_axis_tuser;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [63:0]  cfg_data;

	ascon_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int recv_hold;
	int quiet_cycles;
	int n_sent;

	ascon_aead_engine_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random stalls plus an optional long hold
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (recv_hold > 0) begin
				recv_hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	always @(posedge clk) begin
		if (quiet_cycles >= StallLimit) begin
			$display("[ascon_aead_engine_top] ERROR");
			$finish;
		end
	end

	task automatic send(logic [2:0] act, logic [7:0] data, logic [63:0] nu, logic [63:0] nl);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {nl, nu, data};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(act, data, nu, nl);
		n_sent++;
	endtask

	task automatic send_rand(logic [2:0] act);
		send(act, 8'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
	endtask

	task automatic go_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		// start and permuting requests leave no result; let them finish
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_cfg(logic [63:0] khi, logic [63:0] klo, logic rate, logic [3:0] rnd,
			logic [1:0] mode);
		logic [63:0] vals[5];
		vals = '{khi, klo, {63'd0, rate}, {60'd0, rnd}, {62'd0, mode}};
		for (int i = 0; i < 5; i++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			sb.write_reg(3'(i), vals[i]);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one well-formed message with random content, sometimes broken
	task automatic send_message();
		int n_ad, n_pl;
		n_ad = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
		n_pl = $urandom_range(0, 24);
		send_rand(ACT_START);
		repeat (n_ad) send_rand(ACT_AD_BYTE);
		send_rand(ACT_END_AD);
		repeat (n_pl) send_rand(ACT_PL_BYTE);
		if ($urandom_range(0, 7) != 0) send_rand(ACT_END_PL);
		send_rand(ACT_FINALIZE);
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 4)) send_rand(3'($urandom_range(0, 7)));
	endtask

	initial begin
		int sent;
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 22;
		recv_idle_pct = 70;
		recv_hold = 0;
		quiet_cycles = 0;
		n_sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset settings first, then field extremes and odd orders
		send(ACT_START, 8'h00, '0, '0);
		send(ACT_END_AD, 8'h00, '0, '0);
		send(ACT_PL_BYTE, 8'h00, '0, '0);
		send(ACT_PL_BYTE, 8'hff, '0, '0);
		send(ACT_END_PL, 8'h00, '0, '0);
		send(ACT_FINALIZE, 8'h00, '0, '0);
		go_idle();
		write_cfg('1, '1, 1'b1, 4'd12, MODE_DEC);
		send(ACT_START, 8'hff, '1, '1);
		send(ACT_AD_BYTE, 8'hff, '1, '1);
		send(ACT_AD_BYTE, 8'h00, '0, '0);
		send(ACT_END_AD, 8'h5a, '0, '0);
		repeat (17) send_rand(ACT_PL_BYTE);
		send(ACT_END_PL, 8'h00, '0, '0);
		send(ACT_UNUSED_6, 8'hff, '1, '1);
		send(ACT_UNUSED_7, 8'h00, '0, '0);
		send(ACT_FINALIZE, 8'h00, '0, '0);
		send(ACT_FINALIZE, 8'h00, '0, '0);
		send(ACT_PL_BYTE, 8'h3c, '0, '0);
		go_idle();
		// switch to the narrow rate and send requests without a new start
		write_cfg('0, '0, 1'b0, 4'd0, MODE_UNUSED);
		repeat (3) send_rand(ACT_AD_BYTE);
		send_rand(ACT_PL_BYTE);
		send_rand(ACT_FINALIZE);
		go_idle();

		// random phases
		for (int ph = 0; ph < 9; ph++) begin
			case (ph % 3)
				0: begin send_idle_pct = 22; recv_idle_pct = 70; end
				1: begin send_idle_pct = 70; recv_idle_pct = 22; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			case (ph)
				0: write_cfg({$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 4'd6, MODE_ENC);
				1: write_cfg({$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 4'd1, MODE_DEC);
				2: write_cfg('1, '0, 1'b1, 4'd15, MODE_ABSORB);
				3: write_cfg('0, '1, 1'b0, 4'd12, MODE_DEC);
				4: write_cfg({$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 4'd8, MODE_ENC);
				5: write_cfg({$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 4'd0,
						MODE_UNUSED);
				default: write_cfg({$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom),
						4'($urandom_range(1, 12)), 2'($urandom_range(0, 1)));
			endcase
			// hold the receiver off while requests keep coming
			if (ph == 2) recv_hold = 300;
			sent = n_sent;
			while (n_sent - sent < PhaseItems) begin
				send_message();
			end
			go_idle();
		end

		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.errors == 0)
			$display("[ascon_aead_engine_top] OK");
		else
			$display("[ascon_aead_engine_top] ERROR");
		$finish;
	end
endmodule

`default_nettype wire
